>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Holds the character map, the status codes and the job format that the
// front part hands to the back part through the job queue.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Character classes beyond the 64 sextet values
  localparam logic [6:0] CODE_SKIP = 7'd64;
  localparam logic [6:0] CODE_PAD  = 7'd65;
  localparam logic [6:0] CODE_BAD  = 7'd66;

  // Status codes reported on the final beat
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int unsigned CAP_W   = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  // One job: up to three data bytes, then optionally the status beat.
  // data holds the first byte in bits [23:16].
  typedef struct packed {
    logic [23:0]      data;
    logic [1:0]       nbytes;
    logic             fin;
    logic [1:0]       status;
    logic [CAP_W-1:0] count;
  } job_t;

  // Map one text byte onto its sextet value or a character class
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] code;
    code = CODE_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      code = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      code = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      code = 7'd62;
    end else if (c == 8'h2F) begin
      code = 7'd63;
    end else if (c == 8'h0A) begin
      code = CODE_SKIP;
    end else if (c == 8'h3D) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

endpackage

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character classification and group assembly
// Accepts one character per beat, collects sextets, checks the byte budget
// against the capacity register and posts one job per beat that yields beats.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [b64d_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  input  logic [7:0]                   in_char,
  input  logic                         in_last,
  input  logic                         in_ready,
  output logic                         push,
  output b64d_pkg::job_t               job
);

  logic [17:0]                 sbuf;
  logic [1:0]                  scnt;
  logic [b64d_pkg::CAP_W-1:0]  bytes_out;
  logic                        pad_seen;
  logic [1:0]                  err;
  logic [b64d_pkg::CAP_W-1:0]  capacity;

  logic [17:0]                 sbuf_next;
  logic [1:0]                  scnt_next;
  logic [b64d_pkg::CAP_W-1:0]  bytes_out_next;
  logic                        pad_seen_next;
  logic [1:0]                  err_next;

  logic                        accept;
  logic [6:0]                  code;
  logic                        active;
  logic                        is_sext;
  logic                        grp;
  logic [1:0]                  need;
  logic [b64d_pkg::CAP_W:0]    total;
  logic                        over;

  assign accept = in_valid && in_ready;

  // Classify the character and work out the beat's job
  always_comb begin
    code    = b64d_pkg::map_char(in_char);
    active  = (err == b64d_pkg::ST_OK) && !pad_seen;
    is_sext = active && (code < b64d_pkg::CODE_SKIP);
    grp     = is_sext && (scnt == 2'd3);

    sbuf_next     = sbuf;
    scnt_next     = scnt;
    pad_seen_next = pad_seen;
    err_next      = err;

    if (grp) begin
      sbuf_next = '0;
      scnt_next = 2'd0;
    end else if (is_sext) begin
      sbuf_next = {sbuf[11:0], code[5:0]};
      scnt_next = scnt + 2'd1;
    end
    if (active && code == b64d_pkg::CODE_BAD) begin
      err_next = b64d_pkg::ST_INVALID;
    end
    if (active && code == b64d_pkg::CODE_PAD) begin
      pad_seen_next = 1'b1;
    end

    // Bytes asked for: a full group, or a flush on the last character
    need = 2'd0;
    if (grp) begin
      need = 2'd3;
    end else if (in_last && err_next == b64d_pkg::ST_OK) begin
      if (scnt_next == 2'd3) begin
        need = 2'd2;
      end else if (scnt_next == 2'd2) begin
        need = 2'd1;
      end
    end

    total = {1'b0, bytes_out} + (b64d_pkg::CAP_W+1)'(need);
    over  = (need != 2'd0) && (total > {1'b0, capacity});

    bytes_out_next = bytes_out;
    if (over) begin
      err_next = b64d_pkg::ST_OVERFLOW;
    end else if (need != 2'd0) begin
      bytes_out_next = total[b64d_pkg::CAP_W-1:0];
    end

    // Assemble the job
    if (grp) begin
      job.data = {sbuf, code[5:0]};
    end else if (scnt_next == 2'd3) begin
      job.data = {sbuf_next[17:10], sbuf_next[9:2], 8'h00};
    end else begin
      job.data = {sbuf_next[11:4], 16'h0000};
    end
    job.nbytes = over ? 2'd0 : need;
    job.fin    = in_last;
    job.status = err_next;
    job.count  = bytes_out_next;

    push = accept && ((job.nbytes != 2'd0) || in_last);
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= b64d_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Advance message state; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf      <= '0;
      scnt      <= 2'd0;
      bytes_out <= '0;
      pad_seen  <= 1'b0;
      err       <= b64d_pkg::ST_OK;
    end else if (accept) begin
      if (in_last) begin
        sbuf      <= '0;
        scnt      <= 2'd0;
        bytes_out <= '0;
        pad_seen  <= 1'b0;
        err       <= b64d_pkg::ST_OK;
      end else begin
        sbuf      <= sbuf_next;
        scnt      <= scnt_next;
        bytes_out <= bytes_out_next;
        pad_seen  <= pad_seen_next;
        err       <= err_next;
      end
    end
  end

endmodule

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: job queue between front and back
// Small register FIFO; push is refused by the front while full.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output b64d_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  b64d_pkg::job_t  slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full       = (fill == DEPTH_C);
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: beat sequencer and output register
// Walks the head job one beat per cycle while the output is free: its data bytes, then the status beat if final.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  b64d_pkg::job_t              head_job,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_final,
  output logic [1:0]                  out_status,
  output logic [b64d_pkg::CAP_W-1:0]  out_count
);

  logic [1:0] idx;
  logic       load;
  logic       emit_byte;
  logic [7:0] sel_byte;

  assign load      = head_valid && (!out_valid || out_ready);
  assign emit_byte = (idx < head_job.nbytes);

  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = head_job.data[23:16];
      2'd1:    sel_byte = head_job.data[15:8];
      default: sel_byte = head_job.data[7:0];
    endcase
    pop = load && (!emit_byte || ((idx == head_job.nbytes - 2'd1) && !head_job.fin));
  end

  // Step through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= pop ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_byte) begin
        out_byte   <= sel_byte;
        out_final  <= 1'b0;
        out_status <= b64d_pkg::ST_OK;
        out_count  <= '0;
      end else begin
        out_byte   <= 8'h00;
        out_final  <= 1'b1;
        out_status <= head_job.status;
        out_count  <= head_job.count;
      end
    end
  end

endmodule

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, standard alphabet
// Path: an accepted character's job is written into the job queue register,
//   then its first output beat is written into the output register.
// Throughput: one character per cycle while the job queue has room; the
//   output side sends one beat per cycle while m_axis_tready is high, so a full group costs 3 beats.
// Reset: clears the message state and the job queue, capacity goes to 65535.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: out_capacity
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // is_last
  // decoded stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [25:10] byte_count
  output logic        m_axis_tlast    // is_final
);

  logic           q_push;
  b64d_pkg::job_t q_in;
  logic           q_pop;
  logic           q_full;
  logic           q_head_valid;
  b64d_pkg::job_t q_head;

  logic [7:0]                  out_byte;
  logic [1:0]                  out_status;
  logic [b64d_pkg::CAP_W-1:0]  out_count;

  assign s_axis_tready = !q_full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_char   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .push      (q_push),
    .job       (q_in)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_byte   (out_byte),
    .out_final  (m_axis_tlast),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // Pack the output beat
  assign m_axis_tdata = {6'b000000, out_count, out_status, out_byte};

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("job popped from empty queue");

  // Data beats carry no status and no count
  a_data_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[25:8] == 18'd0))
    else $error("data beat with status or count set");

  // A status beat never carries a data byte or an unknown status
  a_final_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[9:8] != 2'd3))
    else $error("malformed status beat");

endmodule
